>>> rtl/core/ccrs_pkg.sv
// ----------------------------------------------------------------------------
// ccrs_pkg
// Shared types, constants, control store and CRC helper for the channel
// record store.
// ----------------------------------------------------------------------------
package ccrs_pkg;

  localparam int CHANNELS    = 12;
  localparam int STORE_BYTES = 1024;
  localparam int AW          = $clog2(STORE_BYTES);
  localparam int SUM_W       = 18;
  localparam int UPC_W       = 5;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 10;

  typedef logic [AW-1:0]    addr_t;
  typedef logic [UPC_W-1:0] upc_t;

  // actions
  localparam logic [2:0] ACT_RAW      = 3'd0;
  localparam logic [2:0] ACT_SAVE     = 3'd1;
  localparam logic [2:0] ACT_READ     = 3'd2;
  localparam logic [2:0] ACT_FLAG_WR  = 3'd3;
  localparam logic [2:0] ACT_FLAG_RD  = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_CH  = 2'd1;
  localparam logic [1:0] ST_CRC_ERR = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_END    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TWO_END    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLAG_SET   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FLAG_CLEAR = 3'd4;

  typedef enum logic [2:0] {
    MEM_NONE,
    MEM_RD_ENTRY,
    MEM_RD_CRC,
    MEM_WR_ENTRY,
    MEM_WR_CRC,
    MEM_WR_FLAG
  } mem_op_t;

  typedef enum logic [2:0] {
    ALU_NOP,
    ALU_SAVE_CMP,
    ALU_RD_CAP,
    ALU_CRC_CHK,
    ALU_FLAG_CAP,
    ALU_SET_BAD,
    ALU_IDX_CLR
  } alu_op_t;

  typedef enum logic [2:0] {
    BR_NEXT,
    BR_JUMP,
    BR_MORE,
    BR_SAME,
    BR_DISPATCH,
    BR_END
  } br_op_t;

  typedef struct packed {
    mem_op_t mem;
    alu_op_t alu;
    br_op_t  br;
    upc_t    tgt;
  } ctl_word_t;

  // program labels
  localparam upc_t UP_DISPATCH = 5'd0;
  localparam upc_t UP_RAW      = 5'd1;
  localparam upc_t UP_BAD      = 5'd2;
  localparam upc_t UP_S_RD     = 5'd3;
  localparam upc_t UP_S_CMP    = 5'd4;
  localparam upc_t UP_S_CHK    = 5'd5;
  localparam upc_t UP_S_WR     = 5'd6;
  localparam upc_t UP_S_CRC    = 5'd7;
  localparam upc_t UP_R_RD     = 5'd8;
  localparam upc_t UP_R_CAP    = 5'd9;
  localparam upc_t UP_R_CRD    = 5'd10;
  localparam upc_t UP_R_CHK    = 5'd11;
  localparam upc_t UP_F_RD     = 5'd12;
  localparam upc_t UP_F_WR     = 5'd13;
  localparam upc_t UP_G_RD     = 5'd14;
  localparam upc_t UP_G_CAP    = 5'd15;
  localparam upc_t UP_END      = 5'd16;

  function automatic ctl_word_t ucode(input upc_t pc);
    ctl_word_t w;
    w = '{mem: MEM_NONE, alu: ALU_NOP, br: BR_END, tgt: UP_END};
    case (pc)
      UP_DISPATCH: w = '{MEM_NONE,     ALU_NOP,      BR_DISPATCH, UP_END};
      UP_RAW:      w = '{MEM_WR_ENTRY, ALU_NOP,      BR_JUMP,     UP_END};
      UP_BAD:      w = '{MEM_NONE,     ALU_SET_BAD,  BR_JUMP,     UP_END};
      UP_S_RD:     w = '{MEM_RD_ENTRY, ALU_NOP,      BR_NEXT,     UP_END};
      UP_S_CMP:    w = '{MEM_NONE,     ALU_SAVE_CMP, BR_MORE,     UP_S_RD};
      UP_S_CHK:    w = '{MEM_NONE,     ALU_IDX_CLR,  BR_SAME,     UP_END};
      UP_S_WR:     w = '{MEM_WR_ENTRY, ALU_NOP,      BR_MORE,     UP_S_WR};
      UP_S_CRC:    w = '{MEM_WR_CRC,   ALU_NOP,      BR_JUMP,     UP_END};
      UP_R_RD:     w = '{MEM_RD_ENTRY, ALU_NOP,      BR_NEXT,     UP_END};
      UP_R_CAP:    w = '{MEM_NONE,     ALU_RD_CAP,   BR_MORE,     UP_R_RD};
      UP_R_CRD:    w = '{MEM_RD_CRC,   ALU_NOP,      BR_NEXT,     UP_END};
      UP_R_CHK:    w = '{MEM_NONE,     ALU_CRC_CHK,  BR_JUMP,     UP_END};
      UP_F_RD:     w = '{MEM_RD_ENTRY, ALU_NOP,      BR_NEXT,     UP_END};
      UP_F_WR:     w = '{MEM_WR_FLAG,  ALU_NOP,      BR_JUMP,     UP_END};
      UP_G_RD:     w = '{MEM_RD_ENTRY, ALU_NOP,      BR_NEXT,     UP_END};
      UP_G_CAP:    w = '{MEM_NONE,     ALU_FLAG_CAP, BR_JUMP,     UP_END};
      UP_END:      w = '{MEM_NONE,     ALU_NOP,      BR_END,      UP_END};
      default:     w = '{MEM_NONE,     ALU_NOP,      BR_END,      UP_END};
    endcase
    return w;
  endfunction

  // one byte of reflected CRC-8
  function automatic logic [7:0] crc8_byte(input logic [7:0] acc,
                                           input logic [7:0] data,
                                           input logic [7:0] poly);
    logic [7:0] a;
    a = acc ^ data;
    for (int b = 0; b < 8; b++) begin
      a = a[0] ? ((a >> 1) ^ poly) : (a >> 1);
    end
    return a;
  endfunction

endpackage

>>> rtl/core/ccrs_if.sv
// ----------------------------------------------------------------------------
// ccrs_if
// Valid/ready channels of the channel record store: request and result.
// ----------------------------------------------------------------------------
interface ccrs_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [9:0]  blk_addr;
  logic [3:0]  channel;
  logic [31:0] entry_value;
  logic        flag_mode;

  modport source (output valid, action, blk_addr, channel, entry_value, flag_mode,
                  input ready);
  modport sink   (input valid, action, blk_addr, channel, entry_value, flag_mode,
                  output ready);
endinterface

interface ccrs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] read_data;
  logic        wrote;

  modport source (output valid, status, read_data, wrote, input ready);
  modport sink   (input valid, status, read_data, wrote, output ready);
endinterface

>>> rtl/core/crc_checked_channel_record_store.sv
// ----------------------------------------------------------------------------
// crc_checked_channel_record_store
// CRC-8 protected per-channel record store driven by a microcoded sequencer.
//
// in_ch carries one request beat (action, blk_addr, channel, entry_value,
// flag_mode); out_ch returns one result beat (status, read_data, wrote) per
// request. cfg_we/cfg_idx/cfg_wdata write the CRC polynomial, the two entry
// size thresholds and the two flag bytes; write them only while idle.
// One request at a time: the sequencer steps through a control store, one
// memory access per step over a single-port byte memory with registered
// read data. Save and read walk the entry a byte per step, for an entry
// size of 1, 2 or 4 bytes; a save whose bytes all match the stored entry
// skips its write steps and its CRC write.
// After reset a clearing pass zeroes all 1024 bytes, one byte a cycle;
// in_ch.ready stays low until that pass ends.
// The result register frees the sequencer: a request may be accepted while
// a result waits; if out_ch stalls, the next result holds at its last step
// until the register drains.
// ----------------------------------------------------------------------------
module crc_checked_channel_record_store
  import ccrs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  ccrs_in_if.sink               in_ch,
  ccrs_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [7:0] store_r [STORE_BYTES];

  logic [7:0]  crc_poly_r;
  logic [9:0]  one_end_r, two_end_r;
  logic [7:0]  flag_set_r, flag_clr_r;

  logic        clr_busy_r;
  addr_t       clr_cnt_r;
  logic        busy_r, busy_nxt;
  upc_t        upc_r, upc_nxt;

  logic [2:0]  action_r, action_nxt;
  logic        bad_r, bad_nxt;
  logic [31:0] value_r, value_nxt;
  logic        mode_r, mode_nxt;
  logic [1:0]  sz_r, sz_nxt;
  addr_t       addr_r, addr_nxt;
  addr_t       crc_ptr_r, crc_ptr_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic        same_r, same_nxt;
  logic [31:0] data_r, data_nxt;
  logic [1:0]  status_r, status_nxt;
  logic        wrote_r, wrote_nxt;
  logic [7:0]  rd_q_r;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic [31:0] out_data_r, out_data_nxt;
  logic        out_wrote_r, out_wrote_nxt;

  ctl_word_t   ctl;
  logic        accept;
  logic        mem_we, mem_re;
  addr_t       mem_wa, mem_ra;
  logic [7:0]  mem_wd;
  addr_t       ent_addr;
  logic [7:0]  val_byte;
  logic [7:0]  flag_val;
  logic [1:0]  last_idx;
  logic        in_bad;
  logic [1:0]  in_sz, in_shift;
  logic [SUM_W-1:0] ch_off, sum_entry, sum_crc;

  assign in_ch.ready      = !busy_r && !clr_busy_r;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.read_data = out_data_r;
  assign out_ch.wrote     = out_wrote_r;

  assign accept   = in_ch.valid && in_ch.ready;
  assign ctl      = ucode(upc_r);
  assign ent_addr = addr_r + addr_t'(idx_r);
  assign val_byte = value_r[{idx_r, 3'b000} +: 8];
  assign flag_val = mode_r ? flag_set_r : flag_clr_r;
  assign last_idx = (sz_r == 2'd0) ? 2'd0 : (sz_r == 2'd1) ? 2'd1 : 2'd3;

  // request decode at accept
  always_comb begin
    in_bad = (in_ch.channel == 4'd0) || (32'(in_ch.channel) > 32'(CHANNELS));
    if (in_ch.blk_addr <= one_end_r) begin
      in_sz = 2'd0;
    end else if (in_ch.blk_addr <= two_end_r) begin
      in_sz = 2'd1;
    end else begin
      in_sz = 2'd2;
    end
    in_shift  = (in_ch.action == ACT_SAVE || in_ch.action == ACT_READ) ? in_sz : 2'd0;
    ch_off    = SUM_W'(in_ch.channel) - SUM_W'(1);
    sum_entry = SUM_W'(in_ch.blk_addr)
              + ((in_ch.action == ACT_RAW) ? '0 : (ch_off << in_shift));
    sum_crc   = SUM_W'(in_ch.blk_addr) + (SUM_W'(CHANNELS) << in_sz) + ch_off;
  end

  always_comb begin
    busy_nxt       = busy_r;
    upc_nxt        = upc_r;
    action_nxt     = action_r;
    bad_nxt        = bad_r;
    value_nxt      = value_r;
    mode_nxt       = mode_r;
    sz_nxt         = sz_r;
    addr_nxt       = addr_r;
    crc_ptr_nxt    = crc_ptr_r;
    idx_nxt        = idx_r;
    crc_nxt        = crc_r;
    same_nxt       = same_r;
    data_nxt       = data_r;
    status_nxt     = status_r;
    wrote_nxt      = wrote_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_wrote_nxt  = out_wrote_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_wa         = ent_addr;
    mem_ra         = ent_addr;
    mem_wd         = val_byte;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (clr_busy_r) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_r;
      mem_wd = 8'd0;
    end else if (busy_r) begin
      case (ctl.mem)
        MEM_RD_ENTRY: begin
          mem_re = 1'b1;
        end
        MEM_RD_CRC: begin
          mem_re = 1'b1;
          mem_ra = crc_ptr_r;
        end
        MEM_WR_ENTRY: begin
          mem_we    = 1'b1;
          wrote_nxt = 1'b1;
        end
        MEM_WR_CRC: begin
          mem_we    = 1'b1;
          mem_wa    = crc_ptr_r;
          mem_wd    = crc_r;
          wrote_nxt = 1'b1;
        end
        MEM_WR_FLAG: begin
          mem_wd = flag_val;
          if (rd_q_r != flag_val) begin
            mem_we    = 1'b1;
            wrote_nxt = 1'b1;
          end
        end
        default: begin
        end
      endcase

      case (ctl.alu)
        ALU_SAVE_CMP: begin
          if (rd_q_r != val_byte) same_nxt = 1'b0;
          crc_nxt = crc8_byte(crc_r, val_byte, crc_poly_r);
        end
        ALU_RD_CAP: begin
          data_nxt[{idx_r, 3'b000} +: 8] = rd_q_r;
          crc_nxt = crc8_byte(crc_r, rd_q_r, crc_poly_r);
        end
        ALU_CRC_CHK: begin
          if (crc_r != rd_q_r) status_nxt = ST_CRC_ERR;
        end
        ALU_FLAG_CAP: begin
          data_nxt = {24'd0, rd_q_r};
        end
        ALU_SET_BAD: begin
          status_nxt = ST_BAD_CH;
        end
        ALU_IDX_CLR: begin
          idx_nxt = 2'd0;
        end
        default: begin
        end
      endcase

      case (ctl.br)
        BR_NEXT: begin
          upc_nxt = upc_r + upc_t'(1);
        end
        BR_JUMP: begin
          upc_nxt = ctl.tgt;
        end
        BR_MORE: begin
          idx_nxt = idx_r + 2'd1;
          upc_nxt = (idx_r != last_idx) ? ctl.tgt : upc_r + upc_t'(1);
        end
        BR_SAME: begin
          upc_nxt = same_r ? ctl.tgt : upc_r + upc_t'(1);
        end
        BR_DISPATCH: begin
          if (action_r == ACT_RAW) begin
            upc_nxt = UP_RAW;
          end else if (action_r > ACT_FLAG_RD) begin
            upc_nxt = UP_END;
          end else if (bad_r) begin
            upc_nxt = UP_BAD;
          end else begin
            case (action_r)
              ACT_SAVE:    upc_nxt = UP_S_RD;
              ACT_READ:    upc_nxt = UP_R_RD;
              ACT_FLAG_WR: upc_nxt = UP_F_RD;
              ACT_FLAG_RD: upc_nxt = UP_G_RD;
              default:     upc_nxt = UP_END;
            endcase
          end
        end
        BR_END: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = status_r;
            out_data_nxt   = data_r;
            out_wrote_nxt  = wrote_r;
            busy_nxt       = 1'b0;
          end
        end
        default: begin
          upc_nxt = UP_END;
        end
      endcase
    end

    if (accept) begin
      busy_nxt     = 1'b1;
      upc_nxt      = UP_DISPATCH;
      action_nxt   = in_ch.action;
      bad_nxt      = in_bad;
      value_nxt    = in_ch.entry_value;
      mode_nxt     = in_ch.flag_mode;
      sz_nxt       = in_sz;
      addr_nxt     = sum_entry[AW-1:0];
      crc_ptr_nxt  = sum_crc[AW-1:0];
      idx_nxt      = 2'd0;
      crc_nxt      = 8'd0;
      same_nxt     = 1'b1;
      data_nxt     = 32'd0;
      status_nxt   = ST_OK;
      wrote_nxt    = 1'b0;
    end
  end

  // byte memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_r[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q_r <= store_r[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_poly_r <= 8'd140;
      one_end_r  <= 10'd255;
      two_end_r  <= 10'd511;
      flag_set_r <= 8'd1;
      flag_clr_r <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_CRC_POLY:   crc_poly_r <= cfg_wdata[7:0];
        CFG_ONE_END:    one_end_r  <= cfg_wdata;
        CFG_TWO_END:    two_end_r  <= cfg_wdata;
        CFG_FLAG_SET:   flag_set_r <= cfg_wdata[7:0];
        CFG_FLAG_CLEAR: flag_clr_r <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_cnt_r   <= '0;
      busy_r      <= 1'b0;
      upc_r       <= UP_DISPATCH;
      out_valid_r <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + addr_t'(1);
        if (&clr_cnt_r) clr_busy_r <= 1'b0;
      end
      busy_r      <= busy_nxt;
      upc_r       <= upc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    action_r     <= action_nxt;
    bad_r        <= bad_nxt;
    value_r      <= value_nxt;
    mode_r       <= mode_nxt;
    sz_r         <= sz_nxt;
    addr_r       <= addr_nxt;
    crc_ptr_r    <= crc_ptr_nxt;
    idx_r        <= idx_nxt;
    crc_r        <= crc_nxt;
    same_r       <= same_nxt;
    data_r       <= data_nxt;
    status_r     <= status_nxt;
    wrote_r      <= wrote_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_wrote_r  <= out_wrote_nxt;
  end

endmodule
